@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define STC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("stc assertion failed");
// antecedent at one edge implies consequent at the next edge
`define STC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("stc assertion failed");
`else
`define STC_ASSERT(lbl, clk, rstn, prop)
`define STC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/stc_pkg.sv @@
package stc_pkg;

	localparam int unsigned MINUTE_MS = 60000;
	localparam logic [15:0] PRESET_MAX = 16'hFFFF;
	localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;
	localparam logic [15:0] REDRAW_PERIOD_RST = 16'd100;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_RIGHT = 3'd1,
		CMD_LEFT  = 3'd2,
		CMD_ENTER = 3'd3,
		CMD_BACK  = 3'd4
	} cmd_t;

	typedef enum logic {
		CFG_BLINK_PERIOD  = 1'b0,
		CFG_REDRAW_PERIOD = 1'b1
	} cfg_idx_t;

	// timer state carried from item to item
	typedef struct packed {
		logic        mode;
		logic        running;
		logic        finished;
		logic        blink;
		logic [15:0] preset;
		logic [31:0] preset_ms;
		logic [31:0] elapsed;
		logic [31:0] remaining;
		logic [31:0] last_tick;
		logic [31:0] last_redraw;
		logic [31:0] last_blink;
	} state_t;

	// one result beat
	typedef struct packed {
		logic        timer_mode;
		logic        is_running;
		logic        is_finished;
		logic        blank_display;
		logic [15:0] preset_minutes;
		logic [31:0] elapsed_ms;
		logic [31:0] remaining_ms;
		logic        handled;
		logic        redraw;
	} res_t;

endpackage

@@ src/stc_core.sv @@
`include "assert_macros.svh"

module stc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [2:0]    command,
	input  logic [31:0]   now_ms,
	input  logic [15:0]   blink_period,
	input  logic [15:0]   redraw_period,
	output stc_pkg::res_t res
);
	import stc_pkg::*;

	localparam logic [31:0] MinuteMs = 32'(MINUTE_MS);

	state_t st_q;
	state_t st_d;

	logic [31:0] dt_tick;
	logic [31:0] dt_redraw;
	logic [31:0] dt_blink;
	logic        blink_due;
	logic        redraw_due;
	logic        handled;
	logic        redraw;
	logic        is_clear;

	// time since the stored stamps, modulo 2^32
	assign dt_tick    = now_ms - st_q.last_tick;
	assign dt_redraw  = now_ms - st_q.last_redraw;
	assign dt_blink   = now_ms - st_q.last_blink;
	assign blink_due  = dt_blink >= {16'd0, blink_period};
	assign redraw_due = dt_redraw >= {16'd0, redraw_period};
	assign is_clear   = (st_q.preset == '0) && (st_q.elapsed == '0) &&
		!st_q.running && !st_q.finished;

	// next state for the item in the input register
	always_comb begin
		st_d    = st_q;
		handled = 1'b1;
		redraw  = 1'b0;
		case (cmd_t'(command))
			CMD_TICK: begin
				if (st_q.finished) begin
					if (blink_due) begin
						st_d.last_blink = now_ms;
						st_d.blink      = ~st_q.blink;
						redraw          = 1'b1;
					end
				end else if (st_q.running) begin
					st_d.last_tick = now_ms;
					if (!st_q.mode) begin
						st_d.elapsed = st_q.elapsed + dt_tick;
					end else if (dt_tick >= st_q.remaining) begin
						st_d.remaining  = '0;
						st_d.finished   = 1'b1;
						st_d.running    = 1'b0;
						st_d.last_blink = now_ms;
						st_d.blink      = 1'b1;
					end else begin
						st_d.remaining = st_q.remaining - dt_tick;
					end
					if (redraw_due) begin
						st_d.last_redraw = now_ms;
						redraw           = 1'b1;
					end
				end
			end
			CMD_RIGHT, CMD_LEFT: begin
				if (!st_q.running && !st_q.finished) begin
					// preset in ms is kept alongside the preset, stepped by one minute
					if (cmd_t'(command) == CMD_RIGHT && st_q.preset != PRESET_MAX) begin
						st_d.preset    = st_q.preset + 16'd1;
						st_d.preset_ms = st_q.preset_ms + MinuteMs;
					end else if (cmd_t'(command) == CMD_LEFT && st_q.preset != '0) begin
						st_d.preset    = st_q.preset - 16'd1;
						st_d.preset_ms = st_q.preset_ms - MinuteMs;
					end
					st_d.remaining = st_d.preset_ms;
					st_d.mode      = (st_d.preset != '0);
					redraw         = 1'b1;
				end
			end
			CMD_ENTER: begin
				if (st_q.finished) begin
					st_d.finished  = 1'b0;
					st_d.blink     = 1'b1;
					st_d.remaining = st_q.preset_ms;
					st_d.running   = 1'b0;
				end else if (st_q.running) begin
					st_d.running = 1'b0;
				end else begin
					if (st_q.mode && st_q.preset != '0 && st_q.remaining == '0) begin
						st_d.remaining = st_q.preset_ms;
					end
					st_d.last_tick   = now_ms;
					st_d.last_redraw = now_ms;
					st_d.running     = 1'b1;
				end
				redraw = 1'b1;
			end
			CMD_BACK: begin
				if (is_clear) begin
					handled = 1'b0;
				end else begin
					st_d.mode      = 1'b0;
					st_d.running   = 1'b0;
					st_d.finished  = 1'b0;
					st_d.blink     = 1'b1;
					st_d.preset    = '0;
					st_d.preset_ms = '0;
					st_d.elapsed   = '0;
					st_d.remaining = '0;
					redraw         = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result fields reflect the state after the item
	always_comb begin
		res.timer_mode     = st_d.mode;
		res.is_running     = st_d.running;
		res.is_finished    = st_d.finished;
		res.blank_display  = st_d.finished && !st_d.blink;
		res.preset_minutes = st_d.preset;
		res.elapsed_ms     = st_d.elapsed;
		res.remaining_ms   = st_d.remaining;
		res.handled        = handled;
		res.redraw         = redraw;
	end

	// state register, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode        <= 1'b0;
			st_q.running     <= 1'b0;
			st_q.finished    <= 1'b0;
			st_q.blink       <= 1'b1;
			st_q.preset      <= '0;
			st_q.preset_ms   <= '0;
			st_q.elapsed     <= '0;
			st_q.remaining   <= '0;
			st_q.last_tick   <= '0;
			st_q.last_redraw <= '0;
			st_q.last_blink  <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	`STC_ASSERT(a_fin_not_run, clk, arst_n, !(st_q.finished && st_q.running))
	`STC_ASSERT(a_mode_preset, clk, arst_n, st_q.mode == (st_q.preset != '0))
	`STC_ASSERT(a_preset_ms, clk, arst_n,
		st_q.preset_ms == 32'({16'd0, st_q.preset} * MinuteMs))
	`STC_ASSERT_NEXT(a_hold, clk, arst_n, !step, $stable(st_q))
	`STC_ASSERT(a_fin_only_countdown, clk, arst_n, !st_q.finished || st_q.mode)

endmodule

@@ src/stc_out_reg.sv @@
`include "assert_macros.svh"

module stc_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	output logic          load_ready,
	input  stc_pkg::res_t load_res,
	output logic          out_valid,
	input  logic          out_ready,
	output stc_pkg::res_t out_res
);
	import stc_pkg::*;

	logic out_valid_q;
	res_t res_q;

	// the register takes a new beat when empty or when its beat leaves now
	assign load_ready = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign out_res    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ready) begin
			out_valid_q <= load_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			res_q <= load_res;
		end
	end

	`STC_ASSERT_NEXT(a_keep_stalled, clk, arst_n, out_valid_q && !out_ready,
		out_valid_q && $stable(res_q))
	`STC_ASSERT_NEXT(a_load_shows, clk, arst_n, load_valid && load_ready, out_valid_q)
	`STC_ASSERT_NEXT(a_drain, clk, arst_n, out_valid_q && out_ready && !load_valid,
		!out_valid_q)

endmodule

@@ src/stopwatch_countdown_timer.sv @@
// Stopwatch and countdown timer.
// Input channel: in_valid/in_ready carry one command beat (command, now_ms).
// Output channel: out_valid/out_ready carry one result beat per command,
// giving the timer state after that command plus handled and redraw flags.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 blink period, 1 redraw period) in the same cycle; write only while idle.
// Path: a beat accepted on the input channel is captured in the input register,
// processed in one pass against the timer state and loaded into the result
// register once that register can take it, and out_valid then rises.
// Throughput: one beat per cycle while out_ready stays high; the state update
// of one command is a single register step, so the next command sees it.
// Stall: when out_ready is low the result register holds its beat and the
// input register holds one more; in_ready drops only when both are full.
// Reset: arst_n empties both pipeline registers, returns the timer to a
// cleared stopwatch with zero stamps, and restores periods 500 and 100 ms.
module stopwatch_countdown_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        timer_mode,
	output logic        is_running,
	output logic        is_finished,
	output logic        blank_display,
	output logic [15:0] preset_minutes,
	output logic [31:0] elapsed_ms,
	output logic [31:0] remaining_ms,
	output logic        handled,
	output logic        redraw,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import stc_pkg::*;

	logic        valid_s1;
	logic [2:0]  command_s1;
	logic [31:0] now_s1;
	logic        step;
	logic        res_ready;
	logic [15:0] blink_period_q;
	logic [15:0] redraw_period_q;
	res_t        core_res;
	res_t        out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q  <= BLINK_PERIOD_RST;
			redraw_period_q <= REDRAW_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BLINK_PERIOD:  blink_period_q  <= cfg_data;
				CFG_REDRAW_PERIOD: redraw_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register advances when its beat moves into the result register
	assign step     = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			now_s1     <= now_ms;
		end
	end

	stc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.command       (command_s1),
		.now_ms        (now_s1),
		.blink_period  (blink_period_q),
		.redraw_period (redraw_period_q),
		.res           (core_res)
	);

	stc_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (res_ready),
		.load_res   (core_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res)
	);

	// result beat onto the ports
	assign timer_mode     = out_res.timer_mode;
	assign is_running     = out_res.is_running;
	assign is_finished    = out_res.is_finished;
	assign blank_display  = out_res.blank_display;
	assign preset_minutes = out_res.preset_minutes;
	assign elapsed_ms     = out_res.elapsed_ms;
	assign remaining_ms   = out_res.remaining_ms;
	assign handled        = out_res.handled;
	assign redraw         = out_res.redraw;

endmodule
